// ----- src/tgc_pkg.sv -----
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and codes for the touch gesture classifier: request and
// gesture codes, register indexes, reset values and the state record.
// ----------------------------------------------------------------------------
package tgc_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] REQ_PRESS   = 3'd0;
	localparam logic [2:0] REQ_MOVE    = 3'd1;
	localparam logic [2:0] REQ_POLL    = 3'd2;
	localparam logic [2:0] REQ_RELEASE = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	localparam logic [2:0] GEST_NONE        = 3'd0;
	localparam logic [2:0] GEST_TAP         = 3'd1;
	localparam logic [2:0] GEST_LONG_PRESS  = 3'd2;
	localparam logic [2:0] GEST_SWIPE_LEFT  = 3'd3;
	localparam logic [2:0] GEST_SWIPE_RIGHT = 3'd4;

	localparam logic [2:0] REG_TAP_SLOP      = 3'd0;
	localparam logic [2:0] REG_LONG_PRESS_MS = 3'd1;
	localparam logic [2:0] REG_MIN_SWIPE_DIST = 3'd2;
	localparam logic [2:0] REG_MAX_VERT_RATIO = 3'd3;
	localparam logic [2:0] REG_MAX_SWIPE_MS  = 3'd4;
	localparam logic [2:0] REG_MIN_SWIPE_MS  = 3'd5;
	localparam logic [2:0] REG_MAX_TAP_MS    = 3'd6;

	localparam logic [15:0] RST_TAP_SLOP       = 16'd10;
	localparam logic [15:0] RST_LONG_PRESS_MS  = 16'd600;
	localparam logic [15:0] RST_MIN_SWIPE_DIST = 16'd40;
	localparam logic [11:0] RST_MAX_VERT_RATIO = 12'd128;
	localparam logic [15:0] RST_MAX_SWIPE_MS   = 16'd500;
	localparam logic [15:0] RST_MIN_SWIPE_MS   = 16'd0;
	localparam logic [15:0] RST_MAX_TAP_MS     = 16'd300;

	typedef struct packed {
		logic [15:0] tap_slop;
		logic [15:0] long_press_ms;
		logic [15:0] min_swipe_distance;
		logic [11:0] max_vertical_ratio_q8;
		logic [15:0] max_swipe_ms;
		logic [15:0] min_swipe_ms;
		logic [15:0] max_tap_ms;
	} cfg_t;

	typedef struct packed {
		logic               touch_active;
		logic               long_press_reported;
		logic               slop_exceeded;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic [31:0]        start_time;
	} touch_state_t;

endpackage

// ----- src/tgc_regs.sv -----
// ----------------------------------------------------------------------------
// tgc_regs
// APB-style register file holding the classifier thresholds.
// ----------------------------------------------------------------------------
module tgc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tgc_pkg::ADDR_W-1:0] paddr,
	input  logic [tgc_pkg::DATA_W-1:0] pwdata,
	output logic [tgc_pkg::DATA_W-1:0] prdata,
	output tgc_pkg::cfg_t              cfg
);
	import tgc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_slop              <= RST_TAP_SLOP;
			cfg_q.long_press_ms         <= RST_LONG_PRESS_MS;
			cfg_q.min_swipe_distance    <= RST_MIN_SWIPE_DIST;
			cfg_q.max_vertical_ratio_q8 <= RST_MAX_VERT_RATIO;
			cfg_q.max_swipe_ms          <= RST_MAX_SWIPE_MS;
			cfg_q.min_swipe_ms          <= RST_MIN_SWIPE_MS;
			cfg_q.max_tap_ms            <= RST_MAX_TAP_MS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TAP_SLOP:       cfg_q.tap_slop              <= pwdata[15:0];
				REG_LONG_PRESS_MS:  cfg_q.long_press_ms         <= pwdata[15:0];
				REG_MIN_SWIPE_DIST: cfg_q.min_swipe_distance    <= pwdata[15:0];
				REG_MAX_VERT_RATIO: cfg_q.max_vertical_ratio_q8 <= pwdata[11:0];
				REG_MAX_SWIPE_MS:   cfg_q.max_swipe_ms          <= pwdata[15:0];
				REG_MIN_SWIPE_MS:   cfg_q.min_swipe_ms          <= pwdata[15:0];
				REG_MAX_TAP_MS:     cfg_q.max_tap_ms            <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TAP_SLOP:       prdata = {16'd0, cfg_q.tap_slop};
			REG_LONG_PRESS_MS:  prdata = {16'd0, cfg_q.long_press_ms};
			REG_MIN_SWIPE_DIST: prdata = {16'd0, cfg_q.min_swipe_distance};
			REG_MAX_VERT_RATIO: prdata = {20'd0, cfg_q.max_vertical_ratio_q8};
			REG_MAX_SWIPE_MS:   prdata = {16'd0, cfg_q.max_swipe_ms};
			REG_MIN_SWIPE_MS:   prdata = {16'd0, cfg_q.min_swipe_ms};
			REG_MAX_TAP_MS:     prdata = {16'd0, cfg_q.max_tap_ms};
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- src/tgc_classify.sv -----
// ----------------------------------------------------------------------------
// tgc_classify
// Combinational decision logic: from one request and the current touch
// state it forms the next touch state and the reported gesture.
// ----------------------------------------------------------------------------
module tgc_classify (
	input  tgc_pkg::cfg_t         cfg,
	input  tgc_pkg::touch_state_t state_cur,
	input  logic [2:0]            req_type,
	input  logic signed [15:0]    pos_x,
	input  logic signed [15:0]    pos_y,
	input  logic [31:0]           time_ms,
	output tgc_pkg::touch_state_t state_nxt,
	output logic [2:0]            gesture
);
	import tgc_pkg::*;

	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [16:0]        dx_neg;
	logic [16:0]        dy_neg;
	logic [15:0]        adx;
	logic [15:0]        ady;
	logic [31:0]        dur;
	logic [23:0]        vert_scaled;
	logic [27:0]        horiz_scaled;
	logic               far_enough;
	logic               horizontal;
	logic               in_time;
	logic               slop_hit;

	assign dx     = {pos_x[15], pos_x} - {state_cur.start_x[15], state_cur.start_x};
	assign dy     = {pos_y[15], pos_y} - {state_cur.start_y[15], state_cur.start_y};
	assign dx_neg = -dx;
	assign dy_neg = -dy;
	assign adx    = dx[16] ? dx_neg[15:0] : dx[15:0];
	assign ady    = dy[16] ? dy_neg[15:0] : dy[15:0];
	assign dur    = time_ms - state_cur.start_time;

	assign vert_scaled  = {ady, 8'd0};
	assign horiz_scaled = 28'(cfg.max_vertical_ratio_q8) * 28'(adx);
	assign far_enough   = adx >= cfg.min_swipe_distance;
	assign horizontal   = 28'(vert_scaled) <= horiz_scaled;
	assign in_time      = (dur <= 32'(cfg.max_swipe_ms)) && (dur >= 32'(cfg.min_swipe_ms));
	assign slop_hit     = (adx > cfg.tap_slop) || (ady > cfg.tap_slop);

	always_comb begin
		state_nxt = state_cur;
		gesture   = GEST_NONE;
		case (req_type)
			REQ_PRESS: begin
				state_nxt.touch_active        = 1'b1;
				state_nxt.long_press_reported = 1'b0;
				state_nxt.slop_exceeded       = 1'b0;
				state_nxt.start_x             = pos_x;
				state_nxt.start_y             = pos_y;
				state_nxt.start_time          = time_ms;
			end
			REQ_MOVE: begin
				if (state_cur.touch_active && slop_hit) begin
					state_nxt.slop_exceeded = 1'b1;
				end
			end
			REQ_POLL: begin
				if (state_cur.touch_active && !state_cur.long_press_reported &&
				    !state_cur.slop_exceeded && (dur >= 32'(cfg.long_press_ms))) begin
					state_nxt.long_press_reported = 1'b1;
					gesture                       = GEST_LONG_PRESS;
				end
			end
			REQ_RELEASE: begin
				if (state_cur.touch_active) begin
					state_nxt.touch_active = 1'b0;
					if (!state_cur.long_press_reported) begin
						if (far_enough && horizontal && in_time) begin
							gesture = dx[16] ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
						end else if (!state_cur.slop_exceeded &&
						             (dur <= 32'(cfg.max_tap_ms))) begin
							gesture = GEST_TAP;
						end
					end
				end
			end
			REQ_CLEAR: begin
				state_nxt.touch_active        = 1'b0;
				state_nxt.long_press_reported = 1'b0;
				state_nxt.slop_exceeded       = 1'b0;
			end
			default: ;
		endcase
	end

endmodule

// ----- src/touch_gesture_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit
// Classifies press, move, poll, release and clear requests into tap, long
// press and horizontal swipe gestures, one result item per request item.
// ----------------------------------------------------------------------------
// Usage:
// Request items enter on in_valid/in_stall with req_type, pos_x, pos_y and
// time_ms; an item is taken at a clock edge with in_valid high and in_stall
// low. Every request item yields exactly one result item on out_valid/
// out_stall carrying gesture, in request order.
// An item passes one input register and one result register; out_valid rises
// when the item moves from the input register into the result register, which
// a stalled result can delay. The touch state is updated as the item leaves
// the input register. Throughput is one item per cycle while out_stall is low.
// When the receiver stalls, the result register holds its item and one more
// item may still be taken into the input register; in_stall then rises until
// the result is taken.
// Thresholds sit in an APB-style register file; pready is always high. The
// user must write them only while no item is in flight; the block does not
// enforce this. Reset clears the touch state, drops both valid flags and
// loads the threshold defaults.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tgc_pkg::ADDR_W-1:0] paddr,
	input  logic [tgc_pkg::DATA_W-1:0] pwdata,
	output logic [tgc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 req_type,
	input  logic signed [15:0]         pos_x,
	input  logic signed [15:0]         pos_y,
	input  logic [31:0]                time_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 gesture
);
	import tgc_pkg::*;

	cfg_t               cfg;
	touch_state_t       state_q;
	touch_state_t       state_nxt;
	logic               valid_s1;
	logic [2:0]         req_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic [31:0]        t_s1;
	logic               valid_s2;
	logic [2:0]         gesture_s2;
	logic [2:0]         gesture_nxt;
	logic               advance;
	logic               load_s1;

	assign pready    = 1'b1;
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign load_s1   = in_valid && !in_stall;
	assign out_valid = valid_s2;
	assign gesture   = gesture_s2;

	tgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tgc_classify u_classify (
		.cfg       (cfg),
		.state_cur (state_q),
		.req_type  (req_s1),
		.pos_x     (x_s1),
		.pos_y     (y_s1),
		.time_ms   (t_s1),
		.state_nxt (state_nxt),
		.gesture   (gesture_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= req_type;
			x_s1   <= pos_x;
			y_s1   <= pos_y;
			t_s1   <= time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_s2 <= gesture_nxt;
		end
	end

endmodule

// ----- src/tgc_checker.sv -----
// ----------------------------------------------------------------------------
// tgc_checker
// Port-level checks on the gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tgc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pready,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [2:0]                 gesture
);
	import tgc_pkg::*;

	// A stalled result item keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gesture))
		else $error("result item changed while stalled");

	// Only the defined gesture codes leave the block.
	a_gesture_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gesture == GEST_NONE) || (gesture == GEST_TAP) ||
		              (gesture == GEST_LONG_PRESS) || (gesture == GEST_SWIPE_LEFT) ||
		              (gesture == GEST_SWIPE_RIGHT))
		else $error("undefined gesture code");

	// Requests are never held off while the receiver is taking results.
	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled with a free output");

	// The input stalls only behind a result that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.gesture   (gesture)
);
